// File: hdl/array_list_engine_core_defines.svh
// Assertion macros shared by the array list engine RTL.
`ifndef ARRAY_LIST_ENGINE_CORE_DEFINES_SVH
`define ARRAY_LIST_ENGINE_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define ALC_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("alc: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define ALC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("alc: next-cycle check failed");

`endif

// File: hdl/alc_pkg.sv
// Package with types and constants of the array list engine.
`timescale 1ns / 1ps

package alc_pkg;

  localparam int DATA_W    = 32;
  localparam int CMD_W     = 2;
  localparam int INDEX_W   = 4;
  localparam int POS_W     = 4;
  localparam int COUNT_W   = 5;
  localparam int DEPTH_DEF = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_UPDATE = 2'd3
  } alc_cmd_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } alc_state_e;

  // Search probe handed from cell to cell.
  typedef struct packed {
    logic             vld;
    logic             found;
    logic [POS_W-1:0] pos;
  } alc_probe_t;

  typedef struct packed {
    logic               success;
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] count;
  } alc_res_t;

endpackage

// File: hdl/alc_if.sv
// Handshake interfaces for the command and result channels.
`timescale 1ns / 1ps

interface alc_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [alc_pkg::CMD_W-1:0]           command;
  logic signed [alc_pkg::DATA_W-1:0]   value;
  logic [alc_pkg::INDEX_W-1:0]         index;

  modport source (output valid, output command, output value, output index, input ready);
  modport sink   (input valid, input command, input value, input index, output ready);
endinterface

interface alc_res_if;
  logic                          valid;
  logic                          ready;
  logic                          success;
  logic [alc_pkg::POS_W-1:0]     position;
  logic [alc_pkg::COUNT_W-1:0]   count;

  modport source (output valid, output success, output position, output count, input ready);
  modport sink   (input valid, input success, input position, input count, output ready);
endinterface

// File: hdl/array_list_engine_core.sv
// Top level of the array list engine: controller, cell chain and result queue.
//
//   channel | dir | payload                          | handshake
//   cmd_i   | in  | command[1:0] value[31:0] index[3:0] | valid/ready
//   res_o   | out | success position[3:0] count[4:0]    | valid/ready
//
// Append, remove and update finish in the accept cycle; the result word is
// registered into the result queue at that edge and shows on res_o behind any earlier result.
// Search sends a probe down the chain of DEPTH cells, one cell per cycle, and
// its result is queued when the probe leaves the last cell; no command is
// taken meanwhile. Reset empties the list, drops any probe and the queue.
// A two-word result queue lets a new command in while a result waits; ready
// drops only while the queue is full or a search runs.
`timescale 1ns / 1ps

`include "array_list_engine_core_defines.svh"

module array_list_engine_core #(
  parameter int DEPTH = alc_pkg::DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  alc_cmd_if.sink       cmd_i,
  alc_res_if.source     res_o
);
  import alc_pkg::*;

  // Fill count needs to hold DEPTH itself; addresses compare at a common width.
  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (CW > INDEX_W) ? CW : INDEX_W;

  alc_state_e state_d, state_q;
  logic [CW-1:0] cnt_d, cnt_q;
  logic signed [DATA_W-1:0] key_q;
  logic probe_start;
  alc_probe_t probe_q;

  alc_probe_t link [DEPTH+1];
  logic [DEPTH:0] probe_vld;

  logic cmd_acc;
  alc_cmd_e cmd;
  logic [AW-1:0] idx_ext, cnt_ext, wr_addr;
  logic wr_go;

  logic push;
  alc_res_t push_res, head;
  logic head_vld, q_full;

  // Accept only between searches and while the queue has a free slot.
  assign cmd_i.ready = (state_q == ST_IDLE) && !q_full;
  assign cmd_acc     = cmd_i.valid && cmd_i.ready;
  assign cmd         = alc_cmd_e'(cmd_i.command);
  assign idx_ext     = AW'(cmd_i.index);
  assign cnt_ext     = AW'(cnt_q);

  always_comb begin
    state_d           = state_q;
    cnt_d             = cnt_q;
    wr_go             = 1'b0;
    wr_addr           = cnt_ext;
    probe_start       = 1'b0;
    push              = 1'b0;
    push_res.success  = 1'b0;
    push_res.position = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_acc) begin
          unique case (cmd)
            CMD_APPEND: begin
              push = 1'b1;
              if (cnt_q < CW'(DEPTH)) begin
                wr_go            = 1'b1;
                wr_addr          = cnt_ext;
                cnt_d            = cnt_q + CW'(1);
                push_res.success = 1'b1;
              end
            end
            CMD_REMOVE: begin
              push = 1'b1;
              if (cnt_q != '0) begin
                cnt_d            = cnt_q - CW'(1);
                push_res.success = 1'b1;
              end
            end
            CMD_SEARCH: begin
              probe_start = 1'b1;
              state_d     = ST_SCAN;
            end
            CMD_UPDATE: begin
              push = 1'b1;
              // Only a live entry may be overwritten.
              if (idx_ext < cnt_ext) begin
                wr_go            = 1'b1;
                wr_addr          = idx_ext;
                push_res.success = 1'b1;
              end
            end
            default: begin
              push = 1'b0;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // Probe leaving the last cell carries the lowest matching position.
        if (link[DEPTH].vld) begin
          push              = 1'b1;
          push_res.success  = link[DEPTH].found;
          push_res.position = link[DEPTH].found ? link[DEPTH].pos : '0;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    push_res.count = COUNT_W'(cnt_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      probe_q <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      probe_q.vld <= probe_start;
      probe_q.found <= 1'b0;
      probe_q.pos   <= '0;
    end
  end

  // Hold the search key for the whole pass.
  always_ff @(posedge clk_i) begin
    if (probe_start) begin
      key_q <= cmd_i.value;
    end
  end

  assign link[0]      = probe_q;
  assign probe_vld[0] = probe_q.vld;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    alc_cell #(
      .IDX (i),
      .AW  (AW)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .wr_en_i   (wr_go),
      .wr_addr_i (wr_addr),
      .wr_data_i (cmd_i.value),
      .key_i     (key_q),
      .cnt_i     (cnt_ext),
      .probe_i   (link[i]),
      .probe_o   (link[i+1])
    );
    assign probe_vld[i+1] = link[i+1].vld;
  end

  alc_res_queue u_res_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_res),
    .pop_ready_i (res_o.ready),
    .head_vld_o  (head_vld),
    .head_o      (head),
    .full_o      (q_full)
  );

  assign res_o.valid    = head_vld;
  assign res_o.success  = head.success;
  assign res_o.position = head.position;
  assign res_o.count    = head.count;

  // At most one probe travels the chain at any time.
  `ALC_ASSERT_IMPLY(a_one_probe, 1'b1, $onehot0(probe_vld))
  // A probe leaving the last cell is seen only while a search runs.
  `ALC_ASSERT_IMPLY(a_probe_in_scan, link[DEPTH].vld, state_q == ST_SCAN)
  // The list does not change size during a search.
  `ALC_ASSERT_NEXT(a_cnt_stable_scan, state_q == ST_SCAN, cnt_q == $past(cnt_q))
  // The fill count never passes the capacity.
  `ALC_ASSERT_IMPLY(a_cnt_bound, 1'b1, cnt_q <= CW'(DEPTH))

endmodule

// File: hdl/alc_cell.sv
// One list cell: holds an entry and checks the passing search probe.
`timescale 1ns / 1ps

module alc_cell #(
  parameter int IDX = 0,
  parameter int AW  = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              wr_en_i,
  input  logic [AW-1:0]                     wr_addr_i,
  input  logic signed [alc_pkg::DATA_W-1:0] wr_data_i,
  input  logic signed [alc_pkg::DATA_W-1:0] key_i,
  input  logic [AW-1:0]                     cnt_i,
  input  alc_pkg::alc_probe_t               probe_i,
  output alc_pkg::alc_probe_t               probe_o
);
  import alc_pkg::*;

  localparam logic [AW-1:0]    MY_ADDR = AW'(IDX);
  localparam logic [POS_W-1:0] MY_POS  = POS_W'(IDX);

  logic signed [DATA_W-1:0] entry_q;
  alc_probe_t               probe_d, probe_q;
  logic                     hit;

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_addr_i == MY_ADDR)) begin
      entry_q <= wr_data_i;
    end
  end

  // First live entry equal to the key claims the probe.
  assign hit = probe_i.vld && !probe_i.found && (MY_ADDR < cnt_i) && (entry_q == key_i);

  always_comb begin
    probe_d       = probe_i;
    probe_d.found = probe_i.found | hit;
    if (hit) begin
      probe_d.pos = MY_POS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
    end else begin
      probe_q <= probe_d;
    end
  end

  assign probe_o = probe_q;

endmodule

// File: hdl/alc_res_queue.sv
// Two-entry result queue between the engine and the result channel.
`timescale 1ns / 1ps

module alc_res_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  alc_pkg::alc_res_t push_data_i,
  input  logic              pop_ready_i,
  output logic              head_vld_o,
  output alc_pkg::alc_res_t head_o,
  output logic              full_o
);
  import alc_pkg::*;

  alc_res_t s0_d, s0_q, s1_d, s1_q;
  logic     v0_d, v0_q, v1_d, v1_q;
  logic     pop;

  assign pop = v0_q && pop_ready_i;

  always_comb begin
    s0_d = s0_q;
    s1_d = s1_q;
    v0_d = v0_q;
    v1_d = v1_q;
    if (pop) begin
      s0_d = s1_q;
      v0_d = v1_q;
      v1_d = 1'b0;
    end
    if (push_i) begin
      if (!v0_d) begin
        s0_d = push_data_i;
        v0_d = 1'b1;
      end else begin
        s1_d = push_data_i;
        v1_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      v0_q <= v0_d;
      v1_q <= v1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q <= s0_d;
    s1_q <= s1_d;
  end

  assign head_vld_o = v0_q;
  assign head_o     = s0_q;
  assign full_o     = v1_q;

endmodule
